/* rtl/caf_pkg.sv */
// Shared types and constants of the complementary attitude filter.
package caf_pkg;

	// Command codes of an input item
	localparam logic CMD_INTEGRATE = 1'b0;
	localparam logic CMD_FUSE      = 1'b1;

	// Register indexes, taken from paddr[2]
	localparam logic REG_GYRO_SCALE   = 1'b0;
	localparam logic REG_BLEND_WEIGHT = 1'b1;

	localparam logic [31:0] GYRO_SCALE_RST   = 32'd65536;
	localparam logic [16:0] BLEND_WEIGHT_RST = 17'd62259;
	localparam logic [16:0] WEIGHT_ONE       = 17'd65536;

	// Divide by 1000 done one 22-bit digit at a time: digit value < 1000 * 2^22 < 2^32
	localparam int unsigned   CHUNK_W    = 22;
	localparam int unsigned   CHUNK_CNT  = 3;
	localparam logic [31:0]   DIV_CONST  = 32'd1000;
	// floor(2^32 / 1000); the estimate is low by at most one
	localparam logic [32:0]   DIV_RECIP  = 33'd4294967;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MAG,
		ST_LO,
		ST_HI,
		ST_SUM,
		ST_DMUL,
		ST_DFIX,
		ST_APPLY,
		ST_FMUL_A,
		ST_FMUL_E,
		ST_FSUM,
		ST_DONE
	} state_t;

endpackage

/* rtl/complementary_attitude_filter.sv */
// Complementary attitude filter: gyro integration and accelerometer fusion on one multiplier.
//
// The block keeps roll, pitch and yaw estimates (millidegrees, 32-bit, wrapping) and the
// millisecond tick of the last integration. One item goes in at a time and every item gives
// one result item: the three estimates after it. An integrate item (command 0) adds to each
// axis trunc((2*rate + delta) * gyro_scale * dt / 131072000), dt being the tick difference
// modulo 2^32; a fuse item (command 1) blends acc_roll and acc_pitch into roll and pitch with
// blend_weight in Q1.16 (values above 65536 act as 65536), rounding toward zero. All the
// arithmetic runs through one shared 33x33 signed multiplier with a registered product,
// stepped by a small sequencer. An integrate item runs, per axis, three multiplies, one carry
// add and a divide by 1000 in three 22-bit digits, each digit a reciprocal multiply plus one
// correction, then the update. A fuse item runs two multiplies and a rounding add per axis.
// item_ready is high only while no item is in work. The result sits in its own output
// register, so a new item is taken while the previous result waits; the sequencer holds in
// its last step only if the result register is still full. Registers on the APB port:
// gyro_scale at 0x0, blend_weight at 0x4. Write them only while the block is idle.
module complementary_attitude_filter (
	input  logic               clk,
	input  logic               arst_n,
	// configuration
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [2:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	// item channel
	input  logic               item_valid,
	output logic               item_ready,
	input  logic               command,
	input  logic [31:0]        tick_ms,
	input  logic signed [15:0] rate_x,
	input  logic signed [15:0] rate_y,
	input  logic signed [15:0] rate_z,
	input  logic signed [16:0] delta_x,
	input  logic signed [16:0] delta_y,
	input  logic signed [16:0] delta_z,
	input  logic signed [18:0] acc_roll,
	input  logic signed [17:0] acc_pitch,
	// result channel
	output logic               result_valid,
	input  logic               result_ready,
	output logic signed [31:0] roll_est,
	output logic signed [31:0] pitch_est,
	output logic signed [31:0] yaw_est
);

	caf_pkg::state_t state_q, state_d;

	// architectural state
	logic [31:0]        est_q [3];
	logic [31:0]        last_tick_q;
	logic [31:0]        scale_q;
	logic [16:0]        weight_q;

	// sequencer counters
	logic [1:0]         axis_q;
	logic [1:0]         chunk_q;
	logic               result_valid_q;

	// captured item
	logic               cmd_q;
	logic [31:0]        dt_q;
	logic signed [15:0] rate_q  [3];
	logic signed [16:0] delta_q [3];
	logic signed [18:0] acc_roll_q;
	logic signed [17:0] acc_pitch_q;

	// datapath registers
	logic signed [65:0] prod_q;
	logic [63:0]        part_q;
	logic [17:0]        ahi_q;
	logic [65:0]        y_q;
	logic [31:0]        cur_q;
	logic [9:0]         rem_q;
	logic [31:0]        quo_q;
	logic signed [31:0] res_roll_q, res_pitch_q, res_yaw_q;

	// shared multiplier
	logic signed [32:0] mul_a, mul_b;
	logic signed [65:0] mul_p;

	logic               item_take;
	logic               cfg_wr;
	logic               result_load;

	// per-axis selections
	logic signed [15:0] rate_sel;
	logic signed [16:0] delta_sel;
	logic [31:0]        est_sel;
	logic signed [17:0] vel;
	logic               vel_neg;
	logic [17:0]        vel_mag;
	logic signed [32:0] acc_sel;
	logic [16:0]        w_clamp;
	logic [16:0]        w_rest;

	// integrate arithmetic
	logic [49:0]        p_upper;
	logic [21:0]        chunk_sel;
	logic [31:0]        dv_cur;
	logic [22:0]        dv_qe;
	logic [31:0]        dv_sub;
	logic [31:0]        dv_raw;
	logic               dv_fix;
	logic [31:0]        dv_rem;
	logic [22:0]        dv_q;

	// fuse arithmetic
	logic signed [65:0] f_sum;
	logic signed [65:0] f_biased;

	assign pready      = 1'b1;
	assign cfg_wr      = psel && penable && pwrite;
	assign item_take   = item_valid && item_ready;
	assign result_load = (state_q == caf_pkg::ST_DONE) && (!result_valid_q || result_ready);

	assign result_valid = result_valid_q;
	assign roll_est     = res_roll_q;
	assign pitch_est    = res_pitch_q;
	assign yaw_est      = res_yaw_q;

	always_comb begin
		case (paddr[2])
			caf_pkg::REG_GYRO_SCALE: prdata = scale_q;
			default:                 prdata = {15'b0, weight_q};
		endcase
	end

	// ---- per-axis operand selection ----
	always_comb begin
		case (axis_q)
			2'd0: begin
				rate_sel  = rate_q[0];
				delta_sel = delta_q[0];
				est_sel   = est_q[0];
			end
			2'd1: begin
				rate_sel  = rate_q[1];
				delta_sel = delta_q[1];
				est_sel   = est_q[1];
			end
			default: begin
				rate_sel  = rate_q[2];
				delta_sel = delta_q[2];
				est_sel   = est_q[2];
			end
		endcase
	end

	// 2*rate + delta is exact in 18 bits; its magnitude fits 18 unsigned bits
	assign vel     = {rate_sel[15], rate_sel, 1'b0} + {delta_sel[16], delta_sel};
	assign vel_neg = vel[17];
	assign vel_mag = vel_neg ? 18'(-vel) : 18'(vel);

	assign acc_sel = (axis_q == 2'd0) ? 33'(acc_roll_q) : 33'(acc_pitch_q);
	assign w_clamp = (weight_q > caf_pkg::WEIGHT_ONE) ? caf_pkg::WEIGHT_ONE : weight_q;
	assign w_rest  = caf_pkg::WEIGHT_ONE - w_clamp;

	// ---- integrate: product carry, digit select, divide-by-1000 correction ----
	assign p_upper = prod_q[49:0] + {18'b0, part_q[63:32]};

	always_comb begin
		case (chunk_q)
			2'd0:    chunk_sel = y_q[65:44];
			2'd1:    chunk_sel = y_q[43:22];
			default: chunk_sel = y_q[21:0];
		endcase
	end

	assign dv_cur = {rem_q, chunk_sel};
	assign dv_qe  = prod_q[54:32];
	assign dv_sub = {9'b0, dv_qe} * caf_pkg::DIV_CONST;
	assign dv_raw = cur_q - dv_sub;
	assign dv_fix = (dv_raw >= caf_pkg::DIV_CONST);
	assign dv_rem = dv_fix ? (dv_raw - caf_pkg::DIV_CONST) : dv_raw;
	assign dv_q   = dv_qe + {22'b0, dv_fix};

	// ---- fuse: blend sum rounded toward zero ----
	assign f_sum    = {{2{part_q[63]}}, part_q} + prod_q;
	assign f_biased = f_sum + (f_sum[65] ? 66'sd65535 : 66'sd0);

	// ---- shared multiplier ----
	assign mul_p = mul_a * mul_b;

	// ---- sequencer: next state, ready and multiplier operands ----
	always_comb begin
		state_d    = state_q;
		item_ready = 1'b0;
		mul_a      = '0;
		mul_b      = '0;
		case (state_q)
			caf_pkg::ST_IDLE: begin
				item_ready = 1'b1;
				if (item_valid) begin
					state_d = (command == caf_pkg::CMD_FUSE) ? caf_pkg::ST_FMUL_A
						: caf_pkg::ST_MAG;
				end
			end
			caf_pkg::ST_MAG: begin
				mul_a   = {15'b0, vel_mag};
				mul_b   = {1'b0, scale_q};
				state_d = caf_pkg::ST_LO;
			end
			caf_pkg::ST_LO: begin
				mul_a   = {1'b0, prod_q[31:0]};
				mul_b   = {1'b0, dt_q};
				state_d = caf_pkg::ST_HI;
			end
			caf_pkg::ST_HI: begin
				mul_a   = {15'b0, ahi_q};
				mul_b   = {1'b0, dt_q};
				state_d = caf_pkg::ST_SUM;
			end
			caf_pkg::ST_SUM: begin
				state_d = caf_pkg::ST_DMUL;
			end
			caf_pkg::ST_DMUL: begin
				mul_a   = {1'b0, dv_cur};
				mul_b   = caf_pkg::DIV_RECIP;
				state_d = caf_pkg::ST_DFIX;
			end
			caf_pkg::ST_DFIX: begin
				state_d = (chunk_q == 2'(caf_pkg::CHUNK_CNT - 1)) ? caf_pkg::ST_APPLY
					: caf_pkg::ST_DMUL;
			end
			caf_pkg::ST_APPLY: begin
				state_d = (axis_q == 2'd2) ? caf_pkg::ST_DONE : caf_pkg::ST_MAG;
			end
			caf_pkg::ST_FMUL_A: begin
				mul_a   = acc_sel;
				mul_b   = {16'b0, w_clamp};
				state_d = caf_pkg::ST_FMUL_E;
			end
			caf_pkg::ST_FMUL_E: begin
				mul_a   = {est_sel[31], est_sel};
				mul_b   = {16'b0, w_rest};
				state_d = caf_pkg::ST_FSUM;
			end
			caf_pkg::ST_FSUM: begin
				state_d = (axis_q == 2'd1) ? caf_pkg::ST_DONE : caf_pkg::ST_FMUL_A;
			end
			caf_pkg::ST_DONE: begin
				if (!result_valid_q || result_ready) begin
					state_d = caf_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = caf_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= caf_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// ---- control and architectural state ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			est_q[0]       <= '0;
			est_q[1]       <= '0;
			est_q[2]       <= '0;
			last_tick_q    <= '0;
			scale_q        <= caf_pkg::GYRO_SCALE_RST;
			weight_q       <= caf_pkg::BLEND_WEIGHT_RST;
			axis_q         <= '0;
			chunk_q        <= '0;
			result_valid_q <= 1'b0;
		end else begin
			if (cfg_wr) begin
				case (paddr[2])
					caf_pkg::REG_GYRO_SCALE: scale_q  <= pwdata;
					default:                 weight_q <= pwdata[16:0];
				endcase
			end
			if (item_take) begin
				axis_q <= '0;
				// the tick advances only on integrate items
				if (command == caf_pkg::CMD_INTEGRATE) begin
					last_tick_q <= tick_ms;
				end
			end
			case (state_q)
				caf_pkg::ST_SUM: begin
					chunk_q <= '0;
				end
				caf_pkg::ST_DFIX: begin
					chunk_q <= chunk_q + 2'd1;
				end
				caf_pkg::ST_APPLY: begin
					est_q[axis_q] <= est_sel + (vel_neg ? (32'd0 - quo_q) : quo_q);
					axis_q        <= axis_q + 2'd1;
				end
				caf_pkg::ST_FSUM: begin
					est_q[axis_q] <= f_biased[47:16];
					axis_q        <= axis_q + 2'd1;
				end
				default: begin
				end
			endcase
			if (result_load) begin
				result_valid_q <= 1'b1;
			end else if (result_ready) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	// ---- payload registers ----
	always_ff @(posedge clk) begin
		prod_q <= mul_p;
		if (item_take) begin
			cmd_q       <= command;
			dt_q        <= tick_ms - last_tick_q;
			rate_q[0]   <= rate_x;
			rate_q[1]   <= rate_y;
			rate_q[2]   <= rate_z;
			delta_q[0]  <= delta_x;
			delta_q[1]  <= delta_y;
			delta_q[2]  <= delta_z;
			acc_roll_q  <= acc_roll;
			acc_pitch_q <= acc_pitch;
		end
		case (state_q)
			caf_pkg::ST_LO: begin
				// hold the upper bits of |2*rate + delta| * scale for the second partial product
				ahi_q <= prod_q[49:32];
			end
			caf_pkg::ST_HI: begin
				part_q <= prod_q[63:0];
			end
			caf_pkg::ST_SUM: begin
				// full product shifted right by 17, padded to three 22-bit digits
				y_q   <= {1'b0, p_upper, part_q[31:17]};
				rem_q <= '0;
				quo_q <= '0;
			end
			caf_pkg::ST_DMUL: begin
				cur_q <= dv_cur;
			end
			caf_pkg::ST_DFIX: begin
				rem_q <= dv_rem[9:0];
				quo_q <= {quo_q[9:0], dv_q[21:0]};
			end
			caf_pkg::ST_FMUL_E: begin
				part_q <= prod_q[63:0];
			end
			default: begin
			end
		endcase
		if (result_load) begin
			res_roll_q  <= est_q[0];
			res_pitch_q <= est_q[1];
			res_yaw_q   <= est_q[2];
		end
	end

	// ---- assertions ----
	a_div_rem: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == caf_pkg::ST_DFIX) |-> (dv_rem < caf_pkg::DIV_CONST) && (dv_q[22] == 1'b0))
		else $error("divide digit out of range after correction");

	a_fuse_axis: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == caf_pkg::ST_FSUM) |-> (axis_q != 2'd2) && (cmd_q == caf_pkg::CMD_FUSE))
		else $error("fuse step reached the yaw axis");

	a_integ_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == caf_pkg::ST_APPLY) |-> (cmd_q == caf_pkg::CMD_INTEGRATE))
		else $error("integrate step on a fuse item");

	a_tick_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!(item_take && (command == caf_pkg::CMD_INTEGRATE)) |=> $stable(last_tick_q))
		else $error("last tick moved without an integrate item");

	a_result_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid_q) |-> ($past(state_q) == caf_pkg::ST_DONE))
		else $error("result raised outside the final step");

endmodule

/* bench/testbench.sv */
// Self-checking testbench for the complementary attitude filter.
`timescale 1ns / 1ps

module testbench;

	// One input item as it appears on the item channel
	typedef struct packed {
		logic               cmd;
		logic [31:0]        tick;
		logic signed [15:0] rx;
		logic signed [15:0] ry;
		logic signed [15:0] rz;
		logic signed [16:0] dx;
		logic signed [16:0] dy;
		logic signed [16:0] dz;
		logic signed [18:0] ar;
		logic signed [17:0] ap;
	} stim_t;

	// One result item: the three estimates after a command
	typedef struct packed {
		logic signed [31:0] roll;
		logic signed [31:0] pitch;
		logic signed [31:0] yaw;
	} attitude_t;

	// A row of the directed table; known rows carry a hand-read expectation
	typedef struct packed {
		stim_t     item;
		bit        known;
		attitude_t want;
	} directed_row_t;

	// 2 * 1000 ms/s * 2^16 (Q16.16 scale)
	localparam logic [127:0] TICK_DIVISOR = 128'd131072000;
	localparam int RANDOM_PHASES = 5;
	localparam int PHASE_ITEMS   = 80;
	localparam int DRAIN_CYCLES  = 40;

	logic               clk;
	logic               arst_n       = 1'b0;
	logic               psel         = 1'b0;
	logic               penable      = 1'b0;
	logic               pwrite       = 1'b0;
	logic [2:0]         paddr        = '0;
	logic [31:0]        pwdata       = '0;
	logic [31:0]        prdata;
	logic               pready;
	logic               item_valid   = 1'b0;
	logic               item_ready;
	logic               command      = caf_pkg::CMD_INTEGRATE;
	logic [31:0]        tick_ms      = '0;
	logic signed [15:0] rate_x       = '0;
	logic signed [15:0] rate_y       = '0;
	logic signed [15:0] rate_z       = '0;
	logic signed [16:0] delta_x      = '0;
	logic signed [16:0] delta_y      = '0;
	logic signed [16:0] delta_z      = '0;
	logic signed [18:0] acc_roll     = '0;
	logic signed [17:0] acc_pitch    = '0;
	logic               result_valid;
	logic               result_ready = 1'b0;
	logic signed [31:0] roll_est;
	logic signed [31:0] pitch_est;
	logic signed [31:0] yaw_est;

	// Shadow of the block: estimates, last tick and both registers
	logic [31:0] att_est [3] = '{32'd0, 32'd0, 32'd0};
	logic [31:0] prev_tick   = '0;
	logic [31:0] scale_cfg   = caf_pkg::GYRO_SCALE_RST;
	logic [16:0] weight_cfg  = caf_pkg::BLEND_WEIGHT_RST;

	// Estimates still owed by the block, oldest first
	attitude_t pending_att [$];
	int        errors    = 0;
	int        results_n = 0;
	bit        steady    = 1'b0;  // set: neither side idles
	logic [31:0] tick_now = '0;    // running timestamp for random items

	// Directed part, run under the reset register values
	directed_row_t plan [15] = '{
		// zero elapsed time: nothing moves however large the rates
		'{'{caf_pkg::CMD_INTEGRATE, 32'd0, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF,
			17'sh0FFFF, 17'sh0FFFF, 17'sh0FFFF, 19'sd0, 18'sd0},
			1'b1, '{32'sd0, 32'sd0, 32'sd0}},
		// fuse toward zero from zero, junk in every unused field
		'{'{caf_pkg::CMD_FUSE, 32'hFFFF_FFFF, 16'shFFFF, 16'shFFFF, 16'shFFFF,
			17'sh1FFFF, 17'sh1FFFF, 17'sh1FFFF, 19'sd0, 18'sd0},
			1'b1, '{32'sd0, 32'sd0, 32'sd0}},
		// one second at unit scale: rate extremes, negative change truncates toward zero
		'{'{caf_pkg::CMD_INTEGRATE, 32'd1000, 16'sh7FFF, 16'sh8000, 16'sd0,
			17'sd0, 17'sd0, 17'sh10001, -19'sd180000, 18'sd90000},
			1'b1, '{32'sd32767, -32'sd32768, -32'sd32767}},
		'{'{caf_pkg::CMD_FUSE, 32'd0, 16'sd0, 16'sd0, 16'sd0,
			17'sd0, 17'sd0, 17'sd0, 19'sd180000, -18'sd90000}, 1'b0, '0},
		'{'{caf_pkg::CMD_FUSE, 32'd0, 16'sd0, 16'sd0, 16'sd0,
			17'sd0, 17'sd0, 17'sd0, -19'sd180000, 18'sd90000}, 1'b0, '0},
		// tick going backwards: huge wrapped dt, most negative rate sum, estimates wrap
		'{'{caf_pkg::CMD_INTEGRATE, 32'd500, 16'sh8000, 16'sh8000, 16'sh8000,
			17'sh10000, 17'sh10000, 17'sh10000, 19'sd0, 18'sd0}, 1'b0, '0},
		'{'{caf_pkg::CMD_INTEGRATE, 32'hFFFF_FFFF, 16'sh7FFF, 16'sd0, 16'shFFFF,
			17'sh0FFFF, 17'sd0, 17'sd1, 19'sd0, 18'sd0}, 1'b0, '0},
		'{'{caf_pkg::CMD_INTEGRATE, 32'hFFFF_FFFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF,
			17'sh0FFFF, 17'sh0FFFF, 17'sh0FFFF, 19'sd0, 18'sd0}, 1'b0, '0},
		// tick wraps forward through zero
		'{'{caf_pkg::CMD_INTEGRATE, 32'd0, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF,
			17'sh0FFFF, 17'sh0FFFF, 17'sh0FFFF, 19'sd0, 18'sd0}, 1'b0, '0},
		'{'{caf_pkg::CMD_FUSE, 32'h1234_5678, 16'sh1234, 16'sh5678, 16'sh7ABC,
			17'sh1DEF0, 17'sh01357, 17'sh12468, 19'sd0, 18'sd0}, 1'b0, '0},
		'{'{caf_pkg::CMD_INTEGRATE, 32'h5555_5555, 16'sh5555, 16'sh5555, 16'sh5555,
			17'sh05555, 17'sh05555, 17'sh05555, 19'sh15555, 18'sh2AAAA}, 1'b0, '0},
		'{'{caf_pkg::CMD_INTEGRATE, 32'hAAAA_AAAA, 16'shAAAA, 16'shAAAA, 16'shAAAA,
			17'sh1AAAA, 17'sh1AAAA, 17'sh1AAAA, 19'sd0, 18'sd0}, 1'b0, '0},
		'{'{caf_pkg::CMD_FUSE, 32'd0, 16'sd0, 16'sd0, 16'sd0,
			17'sd0, 17'sd0, 17'sd0, 19'sh2AAAA, 18'sh15555}, 1'b0, '0},
		'{'{caf_pkg::CMD_FUSE, 32'd0, 16'sd0, 16'sd0, 16'sd0,
			17'sd0, 17'sd0, 17'sd0, -19'sd174762, -18'sd87381}, 1'b0, '0},
		'{'{caf_pkg::CMD_INTEGRATE, 32'hAAAA_AAB4, 16'sd1, 16'sd1, 16'sd1,
			17'sh1FFFF, 17'sh1FFFF, 17'sh1FFFF, 19'sd0, 18'sd0}, 1'b0, '0}
	};

	complementary_attitude_filter dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.command      (command),
		.tick_ms      (tick_ms),
		.rate_x       (rate_x),
		.rate_y       (rate_y),
		.rate_z       (rate_z),
		.delta_x      (delta_x),
		.delta_y      (delta_y),
		.delta_z      (delta_z),
		.acc_roll     (acc_roll),
		.acc_pitch    (acc_pitch),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.roll_est     (roll_est),
		.pitch_est    (pitch_est),
		.yaw_est      (yaw_est)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Hard stop: far beyond the slowest correct run
	initial begin
		#5_000_000;
		$display("FAILED: results differ");
		$finish;
	end

	// Advance the shadow state by one accepted item and return the new estimates.
	// Integrate: exact trapezoid increment, truncated toward zero, wrapped at 32 bits.
	// Fuse: Q1.16 blend of roll and pitch, weight clamped to one, yaw untouched.
	function automatic attitude_t advance_attitude(input stim_t s);
		logic signed [15:0] rate [3];
		logic signed [16:0] delta [3];
		longint             acc [2];
		logic [31:0]        dt;
		logic [17:0]        mag;
		logic [127:0]       quo;
		logic [31:0]        inc;
		int                 v;
		int                 i;
		longint             w;
		longint             sum;
		attitude_t          r;
		rate  = '{s.rx, s.ry, s.rz};
		delta = '{s.dx, s.dy, s.dz};
		acc   = '{longint'(s.ar), longint'(s.ap)};
		if (s.cmd == caf_pkg::CMD_INTEGRATE) begin
			dt = s.tick - prev_tick;
			prev_tick = s.tick;
			for (i = 0; i < 3; i++) begin
				v = 2 * int'(rate[i]) + int'(delta[i]);
				mag = (v < 0) ? 18'(-v) : 18'(v);
				quo = (128'(mag) * 128'(scale_cfg) * 128'(dt)) / TICK_DIVISOR;
				inc = quo[31:0];
				att_est[i] = att_est[i] + ((v < 0) ? -inc : inc);
			end
		end else begin
			w = (weight_cfg > caf_pkg::WEIGHT_ONE) ? longint'(caf_pkg::WEIGHT_ONE)
				: longint'(weight_cfg);
			for (i = 0; i < 2; i++) begin
				sum = w * acc[i]
					+ (longint'(caf_pkg::WEIGHT_ONE) - w) * longint'(signed'(att_est[i]));
				att_est[i] = 32'(sum / longint'(caf_pkg::WEIGHT_ONE));
			end
		end
		r.roll  = att_est[0];
		r.pitch = att_est[1];
		r.yaw   = att_est[2];
		return r;
	endfunction

	// Mostly full-range rates, now and then a rail
	function automatic logic signed [15:0] pick_rate();
		if ($urandom_range(0, 99) < 10)
			return $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
		return 16'($urandom);
	endfunction

	function automatic logic signed [16:0] pick_delta();
		if ($urandom_range(0, 99) < 10)
			return $urandom_range(0, 1) ? 17'sh0FFFF : 17'sh10000;
		return 17'($urandom);
	endfunction

	// Build one random item. Ticks mostly creep forward by a few ms, with
	// occasional jumps, rewinds and long gaps so dt wraps now and then.
	function automatic stim_t random_item();
		stim_t s;
		int    r;
		s.cmd = ($urandom_range(0, 99) < 60) ? caf_pkg::CMD_INTEGRATE : caf_pkg::CMD_FUSE;
		r = $urandom_range(0, 99);
		if (r < 80)
			tick_now = tick_now + $urandom_range(0, 40);
		else if (r < 90)
			tick_now = $urandom;
		else if (r < 95)
			tick_now = tick_now - $urandom_range(1, 1000);
		else
			tick_now = tick_now + $urandom_range(1000, 100000);
		s.tick = (s.cmd == caf_pkg::CMD_INTEGRATE) ? tick_now : $urandom;
		s.rx = pick_rate();
		s.ry = pick_rate();
		s.rz = pick_rate();
		s.dx = pick_delta();
		s.dy = pick_delta();
		s.dz = pick_delta();
		r = $urandom_range(0, 99);
		if (r < 15) begin
			s.ar = $urandom_range(0, 1) ? 19'sd180000 : -19'sd180000;
			s.ap = $urandom_range(0, 1) ? 18'sd90000 : -18'sd90000;
		end else begin
			s.ar = 19'(int'($urandom_range(0, 360000)) - 180000);
			s.ap = 18'(int'($urandom_range(0, 180000)) - 90000);
		end
		return s;
	endfunction

	// Offer one item, idling first at random; return at the edge it is taken.
	// The expectation is queued right there, long before the result can appear.
	task automatic send_item(input stim_t s, input bit known, input attitude_t want);
		attitude_t pred;
		if (!steady && $urandom_range(0, 99) < 14) begin
			item_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		item_valid <= 1'b1;
		command    <= s.cmd;
		tick_ms    <= s.tick;
		rate_x     <= s.rx;
		rate_y     <= s.ry;
		rate_z     <= s.rz;
		delta_x    <= s.dx;
		delta_y    <= s.dy;
		delta_z    <= s.dz;
		acc_roll   <= s.ar;
		acc_pitch  <= s.ap;
		do @(posedge clk); while (!(item_valid && item_ready));
		pred = advance_attitude(s);
		pending_att.push_back(known ? want : pred);
	endtask

	// Drop valid and hold until every owed result is back, then a short settle
	task automatic drain_results();
		item_valid <= 1'b0;
		wait (pending_att.size() == 0);
		repeat (4) @(posedge clk);
	endtask

	// APB write: setup cycle, then access until pready; mirror it in the shadow
	task automatic write_reg(input logic idx, input logic [31:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		if (idx == caf_pkg::REG_GYRO_SCALE)
			scale_cfg = value;
		else
			weight_cfg = value[16:0];
	endtask

	// Result side: stall at random, about 14 percent of the time, unless steady
	always @(posedge clk) begin
		result_ready <= steady || ($urandom_range(0, 99) >= 14);
	end

	// Compare each taken result with the oldest expectation, field by field
	always @(posedge clk) begin
		attitude_t exp_att;
		if (arst_n && result_valid && result_ready) begin
			results_n++;
			if (pending_att.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected result %0d: roll %0d pitch %0d yaw %0d",
						results_n, roll_est, pitch_est, yaw_est);
			end else begin
				exp_att = pending_att.pop_front();
				if (roll_est !== exp_att.roll || pitch_est !== exp_att.pitch ||
						yaw_est !== exp_att.yaw) begin
					errors++;
					if (errors <= 10)
						$display("result %0d: expected %0d %0d %0d, got %0d %0d %0d",
							results_n, exp_att.roll, exp_att.pitch, exp_att.yaw,
							roll_est, pitch_est, yaw_est);
				end
			end
		end
	end

	// Main sequence: reset, directed table, then random phases with new settings
	initial begin
		logic [31:0] scale_set [RANDOM_PHASES];
		logic [16:0] weight_set [RANDOM_PHASES];
		int          p;
		int          n;
		// extremes first, then unit values, a random pair and the reset values again
		scale_set  = '{32'hFFFF_FFFF, 32'd0, 32'd65536, $urandom, 32'd65536};
		weight_set = '{17'd0, 17'd131071, 17'd65536, 17'($urandom_range(0, 65536)),
			caf_pkg::BLEND_WEIGHT_RST};

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[i])
			send_item(plan[i].item, plan[i].known, plan[i].want);

		for (p = 0; p < RANDOM_PHASES; p++) begin
			drain_results();
			write_reg(caf_pkg::REG_GYRO_SCALE, scale_set[p]);
			write_reg(caf_pkg::REG_BLEND_WEIGHT, 32'(weight_set[p]));
			// one phase runs flat out on both sides
			steady = (p == 2);
			for (n = 0; n < PHASE_ITEMS; n++)
				send_item(random_item(), 1'b0, '0);
		end
		steady = 1'b0;

		item_valid <= 1'b0;
		wait (pending_att.size() == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0 && pending_att.size() == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule
